@@ rtl/core/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [10:0] WIDTH_RESET = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef logic [23:0] pix_t;

    // one emit job handed from the front to the back
    typedef struct packed {
        pix_t [8:0] win;     // row*3+col, row 0 is upper
        logic       top_ok;
        logic       bot_ok;
        logic       left_ok;
        logic       right_ok;
        logic       fend;
    } job_t;

    // mean of n values (n in 1,2,3,4,6,9 after masking) with halves up
    function automatic logic [7:0] div_round(input logic [11:0] s, input logic [3:0] n);
        logic [23:0] p;
        logic [11:0] t;
        begin
            p = '0;
            t = '0;
            unique case (n)
                4'd1: p = {12'd0, s};
                4'd2: p = {12'd0, s + 12'd1} >> 1;
                4'd3: p = ({12'd0, s + 12'd1} * 24'd2731) >> 13;
                4'd4: p = {12'd0, s + 12'd2} >> 2;
                4'd6: p = ({12'd0, s + 12'd3} * 24'd2731) >> 14;
                4'd9: p = ({12'd0, s + 12'd4} * 24'd3641) >> 15;
                default: p = {12'd0, s};
            endcase
            t = p[11:0];
            div_round = t[7:0];
        end
    endfunction

endpackage

@@ rtl/core/bb3_front.sv @@
// ----------------------------------------------------------------------------
// bb3_front
// Scan counters, line stores and window; produces up to two emit jobs per item.
// ----------------------------------------------------------------------------
module bb3_front
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [10:0] width_cfg,
    input  logic [15:0] height_cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_type,
    input  pix_t        in_pix,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    localparam int AW = $clog2(MAX_WIDTH);

    // stage A: load; stage B: line store read data available
    logic        busy_reg, busy_next;
    pix_t        bpx_reg;
    logic [AW-1:0] bcol_reg;
    logic        bemitl_reg, bemitc_reg, bfend_reg, bstore_reg;
    logic [16:0] brow_reg;
    logic [AW:0] col_reg, col_next;
    logic [16:0] row_reg, row_next;
    pix_t        win_reg [9];
    pix_t        up_mem [MAX_WIDTH];
    pix_t        mid_mem [MAX_WIDTH];
    pix_t        up_q, mid_q;
    logic [11:0] w_eff;
    logic [16:0] h_eff;
    logic        out_pend_reg;
    job_t        out_reg;
    logic        out2_pend_reg;
    job_t        out2_reg;

    always_comb
    begin
        if (width_cfg == 11'd0)
            w_eff = 12'd1;
        else if (int'(width_cfg) > MAX_WIDTH)
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = {1'b0, width_cfg};
        h_eff = (height_cfg == 16'd0) ? 17'd1 : {1'b0, height_cfg};
    end

    assign in_ready = !busy_reg && !out_pend_reg && !out2_pend_reg;

    // stage A decisions
    logic [AW:0]  c0;
    logic [16:0]  r0;
    logic         go, emit_l, emit_c, fend, store;
    always_comb
    begin
        c0 = col_reg;
        r0 = row_reg;
        if (12'(col_reg) >= w_eff || r0 > h_eff + 17'd1)
        begin
            c0 = '0;
            r0 = '0;
        end
        go = 1'b0;
        if (in_type == REQ_PIXEL)
        begin
            if (r0 >= h_eff)
            begin
                c0 = '0;
                r0 = '0;
            end
            go = 1'b1;
        end
        else
            go = (r0 >= h_eff);
        emit_l = go && c0 == '0 && r0 >= 17'd2;
        fend = emit_l && r0 == h_eff + 17'd1;
        store = go && !fend;
        emit_c = store && c0 != '0 && r0 >= 17'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (in_valid && in_ready)
        begin
            col_next = c0;
            row_next = r0;
            if (fend)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (go)
            begin
                if (12'(c0) + 12'd1 >= w_eff)
                begin
                    col_next = '0;
                    row_next = r0 + 17'd1;
                end
                else
                    col_next = c0 + (AW+1)'(1);
            end
        end
        busy_next = in_valid && in_ready && go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_next)
        begin
            bpx_reg <= (in_type == REQ_PIXEL) ? in_pix : '0;
            bcol_reg <= c0[AW-1:0];
            bemitl_reg <= emit_l;
            bemitc_reg <= emit_c;
            bfend_reg <= fend;
            bstore_reg <= store;
            brow_reg <= r0;
            up_q <= up_mem[c0[AW-1:0]];
            mid_q <= mid_mem[c0[AW-1:0]];
        end
    end

    // stage B: emit right-edge job (column w-1) on old window, then shift and emit centre job
    job_t jl, jc;
    pix_t wn [9];
    always_comb
    begin
        // centre at window column 2, row r-2, column w-1: left-shift by one
        jl.win = {win_reg[8], win_reg[8], win_reg[7], win_reg[5], win_reg[5],
                  win_reg[4], win_reg[2], win_reg[2], win_reg[1]};
        jl.top_ok = (brow_reg >= 17'd3);
        jl.bot_ok = (brow_reg - 17'd1 < h_eff);
        jl.left_ok = (w_eff >= 12'd2);
        jl.right_ok = 1'b0;
        jl.fend = bfend_reg;
        for (int i = 0; i < 3; i++)
        begin
            wn[i*3] = win_reg[i*3+1];
            wn[i*3+1] = win_reg[i*3+2];
        end
        wn[2] = up_q;
        wn[5] = mid_q;
        wn[8] = bpx_reg;
        jc.win = {wn[8], wn[7], wn[6], wn[5], wn[4], wn[3], wn[2], wn[1], wn[0]};
        jc.top_ok = (brow_reg >= 17'd2);
        jc.bot_ok = (brow_reg < h_eff);
        jc.left_ok = (bcol_reg >= AW'(2));
        jc.right_ok = 1'b1;
        jc.fend = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_pend_reg <= 1'b0;
            out2_pend_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (bstore_reg)
                    for (int i = 0; i < 9; i++)
                        win_reg[i] <= wn[i];
                out_pend_reg <= bemitl_reg || bemitc_reg;
                out2_pend_reg <= bemitl_reg && bemitc_reg;
            end
            else if (job_valid && job_ready)
            begin
                if (out2_pend_reg)
                    out2_pend_reg <= 1'b0;
                else
                    out_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            out_reg <= bemitl_reg ? jl : jc;
            out2_reg <= jc;
            if (bstore_reg)
            begin
                up_mem[bcol_reg] <= mid_q;
                mid_mem[bcol_reg] <= bpx_reg;
            end
        end
        else if (job_valid && job_ready && out2_pend_reg)
            out_reg <= out2_reg;
    end

    assign job_valid = out_pend_reg;
    assign job = out_reg;

endmodule

@@ rtl/core/bb3_back.sv @@
// ----------------------------------------------------------------------------
// bb3_back
// Sums masked window per channel and divides by the in-frame count.
// ----------------------------------------------------------------------------
module bb3_back
    import bb3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        tvalid,
    input  logic        tready,
    output logic [23:0] pix,
    output logic        fend
);

    logic        s_valid_reg;
    logic [11:0] s_reg [3];
    logic [3:0]  n_reg;
    logic        sf_reg;
    logic        o_valid_reg;
    logic [23:0] o_pix_reg;
    logic        o_fend_reg;
    logic        adv;

    logic [11:0] sum [3];
    logic [3:0]  cnt;
    logic        rm [3];
    logic        cm [3];
    always_comb
    begin
        rm[0] = job.top_ok; rm[1] = 1'b1; rm[2] = job.bot_ok;
        cm[0] = job.left_ok; cm[1] = 1'b1; cm[2] = job.right_ok;
        cnt = '0;
        for (int k = 0; k < 3; k++)
            sum[k] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (rm[i] && cm[j])
                begin
                    cnt = cnt + 4'd1;
                    for (int k = 0; k < 3; k++)
                        sum[k] = sum[k] + 12'(job.win[i*3+j][k*8 +: 8]);
                end
    end

    assign adv = !o_valid_reg || tready;
    assign job_ready = !s_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
                s_valid_reg <= job_valid;
            if (adv)
                o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            for (int k = 0; k < 3; k++)
                s_reg[k] <= sum[k];
            n_reg <= cnt;
            sf_reg <= job.fend;
        end
        if (adv && s_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
                o_pix_reg[k*8 +: 8] <= div_round(s_reg[k], n_reg);
            o_fend_reg <= sf_reg;
        end
    end

    assign tvalid = o_valid_reg;
    assign pix = o_pix_reg;
    assign fend = o_fend_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !tready |=> o_valid_reg && $stable(o_pix_reg))
        else $error("output changed while stalled");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> n_reg != 4'd0)
        else $error("empty neighbourhood");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !adv |=> s_valid_reg)
        else $error("sum stage lost");

endmodule

@@ rtl/core/box_blur_3x3_rgb_unit.sv @@
// Path: the first result of a pixel transaction passes the stage B registers,
// the front job register, the back sum register and the output register before
// m_tvalid rises; a second result waits in the front's second job register.
// Flow: a new item is accepted only after the registered line store read, the
// window update and the one-at-a-time job hand-off of its results finish.
// Reset: asynchronous active-low clears counters, window, pipeline valids and
// sets width 640, height 480; line stores are not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// Streaming 3x3 RGB box blur with line stores.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast    // frame_end
);

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        jv, jr;
    job_t        jb;
    logic [23:0] bpix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: width_reg <= cfg_data[10:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .width_cfg(width_reg), .height_cfg(height_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_type(s_tuser),
        .in_pix({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .job_valid(jv), .job_ready(jr), .job(jb));

    bb3_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
        .tvalid(m_tvalid), .tready(m_tready), .pix(bpix), .fend(m_tlast));

    assign m_tdata = {bpix[7:0], bpix[15:8], bpix[23:16]};

endmodule

@@ test/tb_box_blur_3x3_rgb_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_unit
// Self-checking bench for the 3x3 RGB box blur. Frames of varied geometry go
// in raster order, followed by drain transactions. A scoreboard predicts every
// blurred pixel and its end-of-frame mark, and checks each result in order.
// Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_unit;
    import bb3_pkg::*;

    localparam int LINE_MAX = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 920;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } blur_px_t;

    class blur_scoreboard;
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        logic [23:0] upper_line [LINE_MAX];
        logic [23:0] middle_line [LINE_MAX];
        logic [23:0] win [3][3];
        int unsigned col;
        int unsigned row;
        blur_px_t pending_px [$];
        int errors;

        function void reset_state();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (middle_line[i]) middle_line[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col = 0;
            row = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_FRAME_WIDTH)
                width_reg = val[10:0];
            else
                height_reg = val;
        endfunction

        function void blur_at(int orow, int ocol, int cidx, int w, int h, logic fend);
            int unsigned sr, sg, sb, n;
            blur_px_t px;
            sr = 0; sg = 0; sb = 0; n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                if (orow + dr < 0 || orow + dr >= h)
                    continue;
                for (int dc = -1; dc <= 1; dc++) begin
                    if (ocol + dc < 0 || ocol + dc >= w || cidx + dc < 0 || cidx + dc > 2)
                        continue;
                    sr += win[dr + 1][cidx + dc][23:16];
                    sg += win[dr + 1][cidx + dc][15:8];
                    sb += win[dr + 1][cidx + dc][7:0];
                    n++;
                end
            end
            if (n == 0)
                n = 1;
            px.red = 8'((sr + n / 2) / n);
            px.green = 8'((sg + n / 2) / n);
            px.blue = 8'((sb + n / 2) / n);
            px.frame_end = fend;
            pending_px.push_back(px);
        endfunction

        function void shift_in(logic [23:0] pix, int w, int h);
            logic fend;
            if (col == 0 && row >= 2) begin
                fend = (row == h + 1);
                blur_at(row - 2, w - 1, 2, w, h, fend);
                if (fend) begin
                    col = 0;
                    row = 0;
                    return;
                end
            end
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = upper_line[col];
            win[1][2] = middle_line[col];
            win[2][2] = pix;
            upper_line[col] = middle_line[col];
            middle_line[col] = pix;
            if (col >= 1 && row >= 1)
                blur_at(row - 1, col - 1, 1, w, h, 1'b0);
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
        endfunction

        function void note_input(logic req, logic [23:0] data);
            int unsigned w, h;
            w = width_reg;
            h = height_reg;
            if (w == 0) w = 1;
            if (w > LINE_MAX) w = LINE_MAX;
            if (h == 0) h = 1;
            if (col >= w || row > h + 1) begin
                col = 0;
                row = 0;
            end
            if (req == REQ_PIXEL) begin
                if (row >= h) begin
                    col = 0;
                    row = 0;
                end
                shift_in({data[7:0], data[15:8], data[23:16]}, w, h);
            end else if (row >= h) begin
                shift_in('0, w, h);
            end
        endfunction

        function void check_result(logic [23:0] data, logic last);
            blur_px_t px;
            if (pending_px.size() == 0) begin
                $error("unexpected result: data %h last %b", data, last);
                errors++;
                return;
            end
            px = pending_px.pop_front();
            if (data[7:0] !== px.red) begin
                $error("out_red: expected %0d, got %0d", px.red, data[7:0]);
                errors++;
            end
            if (data[15:8] !== px.green) begin
                $error("out_green: expected %0d, got %0d", px.green, data[15:8]);
                errors++;
            end
            if (data[23:16] !== px.blue) begin
                $error("out_blue: expected %0d, got %0d", px.blue, data[23:16]);
                errors++;
            end
            if (last !== px.frame_end) begin
                $error("frame_end: expected %b, got %b", px.frame_end, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [23:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [23:0] m_tdata;
    logic m_tlast;

    blur_scoreboard blur_sb;
    int gap_pct;
    int stall_pct;
    int hold_left;
    int cycle_count;
    int rand_items;

    box_blur_3x3_rgb_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            blur_sb.check_result(m_tdata, m_tlast);
    end

    task automatic send_item(logic req, logic [23:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = data;
        do
            @(posedge clk);
        while (!s_tready);
        blur_sb.note_input(req, data);
    endtask

    task automatic send_pixel(logic [23:0] data);
        send_item(REQ_PIXEL, data);
        rand_items++;
    endtask

    task automatic send_drain();
        send_item(REQ_DRAIN, 24'($urandom));
        rand_items++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (blur_sb.pending_px.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        blur_sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // kind: 0 clean, 1 early drains, 2 short drain (next pixel cuts it), 3 noise
    task automatic run_frame(int w, int h, int kind);
        int total;
        int drains;
        total = w * h;
        for (int i = 0; i < total; i++) begin
            if (kind == 1 && $urandom_range(0, 9) == 0)
                send_drain();
            if (kind == 3 && $urandom_range(0, 3) == 0)
                send_drain();
            else
                send_pixel(24'($urandom));
        end
        drains = (kind == 2) ? $urandom_range(0, w) : w + 1;
        for (int i = 0; i < drains; i++)
            send_drain();
    endtask

    initial
    begin
        int w;
        int h;
        int kind;
        int prev_kind;
        bit long_hold_done;
        blur_sb = new();
        blur_sb.reset_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_PIXEL;
        m_tready = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        rand_items = 0;
        long_hold_done = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_geometry(3, 3);
        send_drain();
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hFF00FF);
        send_drain();
        send_pixel(24'h00FF00);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h010101);
        send_pixel(24'hFEFEFE);
        for (int i = 0; i < 4; i++)
            send_drain();
        set_geometry(0, 0);
        send_pixel(24'hFFFFFF);
        send_drain();
        send_drain();
        set_geometry(1, 1);
        send_pixel(24'h123456);
        send_drain();
        send_drain();

        rand_items = 0;
        prev_kind = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case ((rand_items / 120) % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            kind = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
            if (prev_kind == 2)
                w = blur_sb.width_reg == 0 ? 1 : int'(blur_sb.width_reg);
            if (prev_kind == 2)
                h = blur_sb.height_reg == 0 ? 1 : int'(blur_sb.height_reg);
            else
                set_geometry(w, h);
            if (!long_hold_done && rand_items > 400) begin
                hold_left = 300;
                long_hold_done = 1'b1;
            end
            run_frame(w, h, kind);
            prev_kind = kind;
        end

        gap_pct = 10;
        stall_pct = 10;
        set_geometry(4, 65535);
        for (int i = 0; i < 12; i++)
            send_pixel(24'($urandom));
        set_geometry(2, 2);
        run_frame(2, 2, 0);

        wait_quiet();
        repeat (20) @(posedge clk);
        if (blur_sb.errors == 0 && blur_sb.pending_px.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
